@@ design/ils_pkg.sv @@
`timescale 1ns / 1ps

package ils_pkg;

   localparam int CAPACITY_DEFAULT = 64;

   localparam int KIND_W  = 3;
   localparam int POS_W   = 7;
   localparam int WORD_W  = 32;
   localparam int COUNT_W = 7;
   localparam int STAT_W  = 2;

   localparam logic [KIND_W-1:0] KIND_APPEND    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_OVERWRITE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_READ      = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_INDEX = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   // Operation broadcast to every cell of the chain in the same cycle.
   typedef struct packed {
      logic                     ins;
      logic                     rem;
      logic                     wr;
      logic                     rd;
      logic signed [WORD_W-1:0] word;
   } cmd_type;

endpackage

@@ design/ils_cell.sv @@
`timescale 1ns / 1ps

module ils_cell #(
   parameter int CNT_W = 7,
   parameter int IDX   = 0
) (
   input  logic                             clock,
   input  ils_pkg::cmd_type                 cmd,
   input  logic [CNT_W-1:0]                 pos,
   input  logic signed [ils_pkg::WORD_W-1:0] left_in,
   input  logic signed [ils_pkg::WORD_W-1:0] right_in,
   output logic signed [ils_pkg::WORD_W-1:0] entry_out,
   output logic signed [ils_pkg::WORD_W-1:0] read_out
);

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

   logic signed [ils_pkg::WORD_W-1:0] entry_ff;
   logic signed [ils_pkg::WORD_W-1:0] entry_in;
   logic signed [ils_pkg::WORD_W-1:0] read_ff;
   logic signed [ils_pkg::WORD_W-1:0] read_in;
   logic                              at_pos;
   logic                              above_pos;

   assign at_pos    = (MY_IDX == pos);
   assign above_pos = (MY_IDX > pos);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins) begin
         if (above_pos) begin
            entry_in = left_in;
         end else if (at_pos) begin
            entry_in = cmd.word;
         end
      end else if (cmd.rem) begin
         // close the gap: everything from the removed slot up takes its right neighbor
         if (above_pos || at_pos) begin
            entry_in = right_in;
         end
      end else if (cmd.wr && at_pos) begin
         entry_in = cmd.word;
      end
   end

   assign read_in = (cmd.rd && at_pos) ? entry_ff : '0;

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      read_ff  <= read_in;
   end

   assign entry_out = entry_ff;
   assign read_out  = read_ff;

endmodule

@@ design/ils_chain.sv @@
`timescale 1ns / 1ps

module ils_chain #(
   parameter int CAPACITY = ils_pkg::CAPACITY_DEFAULT,
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                             clock,
   input  ils_pkg::cmd_type                 cmd,
   input  logic [CNT_W-1:0]                 pos,
   output logic signed [ils_pkg::WORD_W-1:0] read_word
);

   logic signed [ils_pkg::WORD_W-1:0] entry_w [CAPACITY];
   logic signed [ils_pkg::WORD_W-1:0] read_w  [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [ils_pkg::WORD_W-1:0] left_w;
      logic signed [ils_pkg::WORD_W-1:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = entry_w[i-1];
      end

      // the top cell holds on a remove; its slot falls out of the count
      if (i == CAPACITY - 1) begin : g_last
         assign right_w = entry_w[i];
      end else begin : g_mid_r
         assign right_w = entry_w[i+1];
      end

      ils_cell #(
         .CNT_W (CNT_W),
         .IDX   (i)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .pos       (pos),
         .left_in   (left_w),
         .right_in  (right_w),
         .entry_out (entry_w[i]),
         .read_out  (read_w[i])
      );
   end

   // at most one cell holds a nonzero read register
   always_comb begin
      read_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_word = read_word | read_w[i];
      end
   end

endmodule

@@ design/indexed_list_store_top.sv @@
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit words held in a chain of cells,
// one entry per cell; insert and remove shift every later entry at once.
// Raise start with req_kind, req_position and req_word_in while busy is low;
// the operation is taken at that edge and busy is high for the next cycle.
// The result appears on the rsp_ ports with rsp_strobe for exactly one cycle,
// registered once more after busy, and must be captured then: there is
// no way to stall it. No new operation is taken while busy is high; in that
// cycle the OR across the cells' read registers gathers the addressed entry.
// A bad index or a full list reports its status and leaves the list unchanged.
module indexed_list_store_top #(
   parameter int CAPACITY = ils_pkg::CAPACITY_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [ils_pkg::KIND_W-1:0]         req_kind,
   input  logic [ils_pkg::POS_W-1:0]          req_position,
   input  logic signed [ils_pkg::WORD_W-1:0]  req_word_in,
   output logic                               rsp_strobe,
   output logic signed [ils_pkg::WORD_W-1:0]  rsp_word_out,
   output logic [ils_pkg::COUNT_W-1:0]        rsp_entry_count,
   output logic [ils_pkg::STAT_W-1:0]         rsp_status
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > ils_pkg::POS_W) ? CNT_W : ils_pkg::POS_W;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

   logic [CNT_W-1:0]                 count_ff;
   logic [CNT_W-1:0]                 count_in;
   logic                             s1_valid_ff;
   logic [ils_pkg::STAT_W-1:0]       s1_status_ff;
   logic [ils_pkg::STAT_W-1:0]       s1_status_in;
   logic [ils_pkg::COUNT_W-1:0]      s1_count_ff;
   logic                             rsp_strobe_ff;
   logic signed [ils_pkg::WORD_W-1:0] rsp_word_ff;
   logic [ils_pkg::COUNT_W-1:0]      rsp_count_ff;
   logic [ils_pkg::STAT_W-1:0]       rsp_status_ff;

   logic                             accept;
   logic                             full;
   logic [CMP_W-1:0]                 pos_c;
   logic [CMP_W-1:0]                 cnt_c;
   logic                             pos_le;
   logic                             pos_lt;
   ils_pkg::cmd_type                 cmd;
   logic [CNT_W-1:0]                 cell_pos;
   logic signed [ils_pkg::WORD_W-1:0] chain_word;

   assign accept = start && !busy;
   assign busy   = s1_valid_ff;
   assign full   = (count_ff == FULL_CNT);
   assign pos_c  = CMP_W'(req_position);
   assign cnt_c  = CMP_W'(count_ff);
   assign pos_le = (pos_c <= cnt_c);
   assign pos_lt = (pos_c < cnt_c);

   always_comb begin
      cmd          = '0;
      cmd.word     = req_word_in;
      cell_pos     = CNT_W'(pos_c);
      s1_status_in = ils_pkg::STAT_OK;
      count_in     = count_ff;
      if (accept) begin
         case (req_kind)
            ils_pkg::KIND_APPEND: begin
               // append is an insert at the tail
               cell_pos = count_ff;
               if (full) begin
                  s1_status_in = ils_pkg::STAT_FULL;
               end else begin
                  cmd.ins  = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            ils_pkg::KIND_INSERT: begin
               if (!pos_le) begin
                  s1_status_in = ils_pkg::STAT_INDEX;
               end else if (full) begin
                  s1_status_in = ils_pkg::STAT_FULL;
               end else begin
                  cmd.ins  = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            ils_pkg::KIND_REMOVE: begin
               if (!pos_lt) begin
                  s1_status_in = ils_pkg::STAT_INDEX;
               end else begin
                  cmd.rem  = 1'b1;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            ils_pkg::KIND_OVERWRITE: begin
               if (!pos_lt) begin
                  s1_status_in = ils_pkg::STAT_INDEX;
               end else begin
                  cmd.wr = 1'b1;
               end
            end
            ils_pkg::KIND_READ: begin
               if (!pos_lt) begin
                  s1_status_in = ils_pkg::STAT_INDEX;
               end else begin
                  cmd.rd = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   ils_chain #(
      .CAPACITY (CAPACITY),
      .CNT_W    (CNT_W)
   ) u_chain (
      .clock     (clock),
      .cmd       (cmd),
      .pos       (cell_pos),
      .read_word (chain_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         s1_valid_ff   <= accept;
         rsp_strobe_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff <= s1_status_in;
         s1_count_ff  <= ils_pkg::COUNT_W'(count_in);
      end
      if (s1_valid_ff) begin
         rsp_word_ff   <= chain_word;
         rsp_count_ff  <= s1_count_ff;
         rsp_status_ff <= s1_status_ff;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_word_out    = rsp_word_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count above capacity");

   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |=> rsp_strobe)
      else $error("accepted transfer produced no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(s1_valid_ff))
      else $error("result strobe without an accepted transfer");

   a_error_holds_count: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_status_ff != ils_pkg::STAT_OK) |-> count_ff == $past(count_ff))
      else $error("failed operation changed the entry count");

endmodule

@@ sim/ils_checker.sv @@
`timescale 1ns / 1ps

module ils_checker #(
   parameter int CAPACITY = ils_pkg::CAPACITY_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic [ils_pkg::KIND_W-1:0]         req_kind,
   input  logic [ils_pkg::POS_W-1:0]          req_position,
   input  logic signed [ils_pkg::WORD_W-1:0]  req_word_in,
   input  logic                               rsp_strobe,
   input  logic signed [ils_pkg::WORD_W-1:0]  rsp_word_out,
   input  logic [ils_pkg::COUNT_W-1:0]        rsp_entry_count,
   input  logic [ils_pkg::STAT_W-1:0]         rsp_status,
   output int                                 outstanding,
   output int                                 fail_count
);

   typedef struct packed {
      logic signed [ils_pkg::WORD_W-1:0] word;
      logic [ils_pkg::COUNT_W-1:0]       count;
      logic [ils_pkg::STAT_W-1:0]        status;
   } list_result_type;

   logic signed [ils_pkg::WORD_W-1:0] list_words [0:CAPACITY-1];
   int                                list_count;
   list_result_type                   pending_results [$];
   int                                mismatches;

   function automatic list_result_type apply_list_op(
      input logic [ils_pkg::KIND_W-1:0]        kind,
      input logic [ils_pkg::POS_W-1:0]         position,
      input logic signed [ils_pkg::WORD_W-1:0] word);
      list_result_type r;
      int              pos;
      int              i;
      pos = int'(position);
      r.word = '0;
      r.status = ils_pkg::STAT_OK;
      case (kind)
         ils_pkg::KIND_APPEND: begin
            if (list_count >= CAPACITY) begin
               r.status = ils_pkg::STAT_FULL;
            end else begin
               list_words[list_count] = word;
               list_count++;
            end
         end
         ils_pkg::KIND_INSERT: begin
            if (pos > list_count) begin
               r.status = ils_pkg::STAT_INDEX;
            end else if (list_count >= CAPACITY) begin
               r.status = ils_pkg::STAT_FULL;
            end else begin
               // shift the tail up to open the slot
               for (i = list_count; i > pos; i--) list_words[i] = list_words[i-1];
               list_words[pos] = word;
               list_count++;
            end
         end
         ils_pkg::KIND_REMOVE: begin
            if (pos >= list_count) begin
               r.status = ils_pkg::STAT_INDEX;
            end else begin
               for (i = pos; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
               list_count--;
            end
         end
         ils_pkg::KIND_OVERWRITE: begin
            if (pos >= list_count) r.status = ils_pkg::STAT_INDEX;
            else list_words[pos] = word;
         end
         ils_pkg::KIND_READ: begin
            if (pos >= list_count) r.status = ils_pkg::STAT_INDEX;
            else r.word = list_words[pos];
         end
         default: begin
         end
      endcase
      r.count = ils_pkg::COUNT_W'(list_count);
      return r;
   endfunction

   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         list_count = 0;
         pending_results.delete();
      end else begin
         // compare first: the oldest expectation belongs to an earlier transfer
         if (rsp_strobe) begin
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result word=%0d count=%0d status=%0d",
                           $realtime, rsp_word_out, rsp_entry_count, rsp_status);
            end else begin
               want = pending_results.pop_front();
               if (rsp_word_out !== want.word || rsp_entry_count !== want.count ||
                   rsp_status !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: expected w=%0d c=%0d s=%0d, got w=%0d c=%0d s=%0d",
                              $realtime, want.word, want.count, want.status,
                              rsp_word_out, rsp_entry_count, rsp_status);
               end
            end
         end
         if (start && !busy)
            pending_results.push_back(apply_list_op(req_kind, req_position, req_word_in));
      end
      outstanding <= pending_results.size();
      fail_count <= mismatches;
   end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

   localparam int CAPACITY = ils_pkg::CAPACITY_DEFAULT;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               start;
   logic                               busy;
   logic [ils_pkg::KIND_W-1:0]         req_kind;
   logic [ils_pkg::POS_W-1:0]          req_position;
   logic signed [ils_pkg::WORD_W-1:0]  req_word_in;
   logic                               rsp_strobe;
   logic signed [ils_pkg::WORD_W-1:0]  rsp_word_out;
   logic [ils_pkg::COUNT_W-1:0]        rsp_entry_count;
   logic [ils_pkg::STAT_W-1:0]         rsp_status;
   int                                 outstanding;
   int                                 fail_count;

   int shadow_count;
   int items_sent;
   int gap_max;

   indexed_list_store_top #(.CAPACITY(CAPACITY)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_position(req_position), .req_word_in(req_word_in),
      .rsp_strobe(rsp_strobe), .rsp_word_out(rsp_word_out),
      .rsp_entry_count(rsp_entry_count), .rsp_status(rsp_status)
   );

   ils_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_position(req_position), .req_word_in(req_word_in),
      .rsp_strobe(rsp_strobe), .rsp_word_out(rsp_word_out),
      .rsp_entry_count(rsp_entry_count), .rsp_status(rsp_status),
      .outstanding(outstanding), .fail_count(fail_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("indexed_list_store_top regression: fail");
      $finish;
   end

   // One transfer; returns right after the accepting edge with start still high.
   task automatic send_op(input logic [ils_pkg::KIND_W-1:0] kind, input int position,
                          input logic signed [ils_pkg::WORD_W-1:0] word);
      int gap;
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_position <= ils_pkg::POS_W'(position);
      req_word_in <= word;
      do @(posedge clock); while (busy);
      items_sent++;
      // track only the entry count, to aim positions
      case (kind)
         ils_pkg::KIND_APPEND: if (shadow_count < CAPACITY) shadow_count++;
         ils_pkg::KIND_INSERT:
            if (position <= shadow_count && shadow_count < CAPACITY) shadow_count++;
         ils_pkg::KIND_REMOVE: if (position < shadow_count) shadow_count--;
         default: begin
         end
      endcase
   endtask

   // Hold off until every transfer has produced its result.
   task automatic drain_list_ops();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (3) @(posedge clock);
   endtask

   function automatic logic [ils_pkg::KIND_W-1:0] pick_kind(input int mode);
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) return ils_pkg::KIND_W'($urandom_range(5, 7));
      case (mode)
         0: begin
            if (r < 40) return ils_pkg::KIND_APPEND;
            if (r < 70) return ils_pkg::KIND_INSERT;
            if (r < 78) return ils_pkg::KIND_REMOVE;
            if (r < 88) return ils_pkg::KIND_OVERWRITE;
            return ils_pkg::KIND_READ;
         end
         1: begin
            if (r < 12) return ils_pkg::KIND_APPEND;
            if (r < 20) return ils_pkg::KIND_INSERT;
            if (r < 70) return ils_pkg::KIND_REMOVE;
            if (r < 82) return ils_pkg::KIND_OVERWRITE;
            return ils_pkg::KIND_READ;
         end
         default: begin
            if (r < 22) return ils_pkg::KIND_APPEND;
            if (r < 40) return ils_pkg::KIND_INSERT;
            if (r < 60) return ils_pkg::KIND_REMOVE;
            if (r < 77) return ils_pkg::KIND_OVERWRITE;
            return ils_pkg::KIND_READ;
         end
      endcase
   endfunction

   function automatic int pick_position(input logic [ils_pkg::KIND_W-1:0] kind);
      int r;
      int top_ok;
      r = $urandom_range(0, 99);
      top_ok = (kind == ils_pkg::KIND_INSERT) ? shadow_count : shadow_count - 1;
      if (top_ok < 0) top_ok = 0;
      if (r < 72) return $urandom_range(0, top_ok);
      if (r < 78) return 0;
      if (r < 84) return top_ok;
      if (r < 90) return shadow_count;
      return $urandom_range(0, (1 << ils_pkg::POS_W) - 1);
   endfunction

   initial begin
      int mode;
      int len;
      int k;
      logic [ils_pkg::KIND_W-1:0] kind;
      reset <= 1'b1;
      start <= 1'b0;
      req_kind <= ils_pkg::KIND_APPEND;
      req_position <= '0;
      req_word_in <= '0;
      shadow_count = 0;
      items_sent = 0;
      gap_max = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty list, word extremes, both ends, bad indexes, unused kinds
      send_op(ils_pkg::KIND_READ, 0, 32'sd0);
      send_op(ils_pkg::KIND_REMOVE, 0, 32'sd0);
      send_op(ils_pkg::KIND_OVERWRITE, 0, -32'sd1);
      send_op(ils_pkg::KIND_INSERT, 1, 32'sd5);
      send_op(ils_pkg::KIND_INSERT, 0, 32'sh7fffffff);
      send_op(ils_pkg::KIND_APPEND, 0, 32'sh80000000);
      send_op(ils_pkg::KIND_APPEND, 127, 32'sd0);
      send_op(ils_pkg::KIND_APPEND, 0, -32'sd1);
      send_op(ils_pkg::KIND_INSERT, 4, 32'sh12345678);
      send_op(ils_pkg::KIND_INSERT, 2, 32'sha5a5a5a5);
      for (k = 0; k < 6; k++) send_op(ils_pkg::KIND_READ, k, 32'sd0);
      send_op(ils_pkg::KIND_READ, 6, 32'sd0);
      send_op(ils_pkg::KIND_OVERWRITE, 5, 32'sh5a5a5a5a);
      send_op(ils_pkg::KIND_READ, 5, 32'sd0);
      send_op(ils_pkg::KIND_REMOVE, 0, 32'sd0);
      send_op(ils_pkg::KIND_REMOVE, 4, 32'sd0);
      send_op(ils_pkg::KIND_READ, 127, 32'sd0);
      send_op(3'd5, 127, -32'sd1);
      send_op(3'd6, 0, 32'sd0);
      send_op(3'd7, 64, -32'sd1);
      send_op(ils_pkg::KIND_REMOVE, 127, 32'sd0);
      drain_list_ops();

      // random phases: grow toward full, shrink toward empty, or mixed
      mode = 0;
      while (items_sent < 1250) begin
         len = (mode == 0) ? $urandom_range(80, 180) : $urandom_range(30, 120);
         gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
         for (k = 0; k < len && items_sent < 1250; k++) begin
            kind = pick_kind(mode);
            send_op(kind, pick_position(kind), $urandom);
         end
         if ($urandom_range(0, 2) == 0) drain_list_ops();
         if (shadow_count >= CAPACITY - 4) mode = $urandom_range(1, 2);
         else if (shadow_count < 8) mode = 0;
         else mode = $urandom_range(0, 2);
      end

      drain_list_ops();
      repeat (4) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("indexed_list_store_top regression: pass");
      end else begin
         $display("indexed_list_store_top regression: fail");
      end
      $finish;
   end

endmodule
